FILE: hw/rtl/fp16ta_pkg.sv
package fp16ta_pkg;

    localparam logic [4:0]  EXP_MAX    = 5'h1F;
    localparam logic [15:0] CANON_NAN  = 16'h7FFF;
    localparam logic [14:0] INF_MAG    = 15'h7C00;
    localparam logic [15:0] NEG_ZERO   = 16'h8000;
    localparam logic [11:0] HIDDEN     = 12'd1024;
    localparam logic [11:0] CARRY      = 12'd2048;
    localparam logic [4:0]  SHIFT_LIM  = 5'd13;

    // Operand classification and ordering, passed from stage one to stage two.
    typedef struct packed {
        logic        special;     // NaN or infinity result, bypasses datapath
        logic [15:0] spec_bits;
        logic        spec_ovf;
        logic        spec_nan;
        logic        s_big;
        logic        s_sml;
        logic [4:0]  e_big;
        logic [10:0] m_big;
        logic [10:0] m_sml;
        logic [4:0]  diff;
    } align_t;

    // After the add or subtract, passed to the normalizer.
    typedef struct packed {
        logic        special;
        logic [15:0] spec_bits;
        logic        spec_ovf;
        logic        spec_nan;
        logic        s_big;
        logic        both_neg;
        logic [4:0]  e_big;
        logic [11:0] mant;
        logic        lost;
    } sum_t;

    // Leading zero count of an 11-bit value, saturated at 11.
    function automatic logic [3:0] lzc11(input logic [10:0] v);
        logic [3:0] n;
        logic       found;
        n = 4'd11;
        found = 1'b0;
        for (int i = 10; i >= 0; i--) begin
            if (!found && v[i]) begin
                n = 4'(10 - i);
                found = 1'b1;
            end
        end
        return n;
    endfunction

endpackage

FILE: hw/rtl/fp16ta_align.sv
module fp16ta_align (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic [15:0]         operand_a,
    input  logic [15:0]         operand_b,
    output logic                out_valid,
    output fp16ta_pkg::align_t  out_data
);

    logic               valid_reg;
    fp16ta_pkg::align_t data_reg;
    fp16ta_pkg::align_t data_next;

    logic        sa, sb, a_inf, b_inf, a_nan, b_nan, swap;
    logic [4:0]  ea, eb, xa, xb;
    logic [9:0]  fa, fb;
    logic [10:0] ma, mb;

    always_comb
    begin
        sa = operand_a[15];
        sb = operand_b[15];
        ea = operand_a[14:10];
        eb = operand_b[14:10];
        fa = operand_a[9:0];
        fb = operand_b[9:0];
        a_inf = (ea == fp16ta_pkg::EXP_MAX) && (fa == '0);
        b_inf = (eb == fp16ta_pkg::EXP_MAX) && (fb == '0);
        a_nan = (ea == fp16ta_pkg::EXP_MAX) && (fa != '0);
        b_nan = (eb == fp16ta_pkg::EXP_MAX) && (fb != '0);
        xa = (ea == '0) ? 5'd1 : ea;
        xb = (eb == '0) ? 5'd1 : eb;
        ma = {(ea != '0), fa};
        mb = {(eb != '0), fb};
        swap = (xa < xb) || ((xa == xb) && (ma < mb));

        data_next.special   = a_nan || b_nan || a_inf || b_inf;
        data_next.spec_nan  = a_nan || b_nan || (a_inf && b_inf && (sa != sb));
        data_next.spec_ovf  = !data_next.spec_nan;
        data_next.spec_bits = data_next.spec_nan ? fp16ta_pkg::CANON_NAN
                            : (a_inf ? operand_a : operand_b);
        data_next.s_big = swap ? sb : sa;
        data_next.s_sml = swap ? sa : sb;
        data_next.e_big = swap ? xb : xa;
        data_next.m_big = swap ? mb : ma;
        data_next.m_sml = swap ? ma : mb;
        data_next.diff  = swap ? (xb - xa) : (xa - xb);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid)
        begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

FILE: hw/rtl/fp16ta_addsub.sv
module fp16ta_addsub (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  fp16ta_pkg::align_t  in_data,
    output logic                out_valid,
    output fp16ta_pkg::sum_t    out_data
);

    logic             valid_reg;
    fp16ta_pkg::sum_t data_reg;
    fp16ta_pkg::sum_t data_next;

    logic        far;
    logic [10:0] shifted;
    logic [10:0] drop_mask;

    always_comb
    begin
        far = (in_data.diff >= fp16ta_pkg::SHIFT_LIM);
        shifted = far ? 11'd0 : (in_data.m_sml >> in_data.diff);
        // At a gap of 11 or more every bit drops, so the mask is all ones.
        drop_mask = (in_data.diff >= 5'd11) ? '1 : ~(11'h7FF << in_data.diff);

        data_next.special   = in_data.special;
        data_next.spec_bits = in_data.spec_bits;
        data_next.spec_ovf  = in_data.spec_ovf;
        data_next.spec_nan  = in_data.spec_nan;
        data_next.s_big     = in_data.s_big;
        data_next.both_neg  = in_data.s_big && in_data.s_sml;
        data_next.e_big     = in_data.e_big;
        data_next.lost      = (in_data.m_sml & drop_mask) != '0;
        data_next.mant = (in_data.s_big == in_data.s_sml)
                       ? ({1'b0, in_data.m_big} + {1'b0, shifted})
                       : ({1'b0, in_data.m_big} - {1'b0, shifted});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid)
        begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

FILE: hw/rtl/fp16ta_norm.sv
module fp16ta_norm (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  fp16ta_pkg::sum_t  in_data,
    output logic              out_valid,
    output logic [15:0]       sum_bits,
    output logic              overflow_flag,
    output logic              zero_flag,
    output logic              nan_flag,
    output logic              inexact_flag
);

    logic        valid_reg;
    logic [15:0] bits_reg, bits_next;
    logic        ovf_reg, ovf_next, zero_reg, zero_next;
    logic        nan_reg, nan_next, lost_reg, lost_next;

    logic [3:0]  lz;
    logic [3:0]  sh;
    logic [5:0]  e;
    logic [11:0] m;
    logic [14:0] mag;

    always_comb
    begin
        lz = fp16ta_pkg::lzc11(in_data.mant[10:0]);
        e = {1'b0, in_data.e_big};
        m = in_data.mant;
        lost_next = in_data.lost;
        sh = '0;
        if (in_data.mant >= fp16ta_pkg::CARRY)
        begin
            lost_next = in_data.lost | in_data.mant[0];
            m = in_data.mant >> 1;
            e = e + 6'd1;
        end
        else
        begin
            // Shift left until normal, but never below exponent one.
            sh = ({1'b0, lz} < {1'b0, in_data.e_big - 5'd1}) ? lz
                                                              : 4'(in_data.e_big - 5'd1);
            m = in_data.mant << sh;
            e = e - {2'b0, sh};
            if ((m < fp16ta_pkg::HIDDEN) && (e == 6'd1))
            begin
                e = '0;
            end
        end
        mag = {e[4:0], m[9:0]};

        ovf_next  = 1'b0;
        zero_next = 1'b0;
        nan_next  = 1'b0;
        if (in_data.special)
        begin
            bits_next = in_data.spec_bits;
            ovf_next  = in_data.spec_ovf;
            nan_next  = in_data.spec_nan;
            lost_next = 1'b0;
        end
        else if (in_data.mant == '0)
        begin
            bits_next = in_data.both_neg ? fp16ta_pkg::NEG_ZERO : 16'h0000;
            zero_next = 1'b1;
        end
        else if (e >= {1'b0, fp16ta_pkg::EXP_MAX})
        begin
            bits_next = {in_data.s_big, fp16ta_pkg::INF_MAG};
            ovf_next  = 1'b1;
        end
        else
        begin
            bits_next = {in_data.s_big, mag};
            zero_next = (mag == '0);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid)
        begin
            bits_reg <= bits_next;
            ovf_reg  <= ovf_next;
            zero_reg <= zero_next;
            nan_reg  <= nan_next;
            lost_reg <= lost_next;
        end
    end

    assign out_valid     = valid_reg;
    assign sum_bits      = bits_reg;
    assign overflow_flag = ovf_reg;
    assign zero_flag     = zero_reg;
    assign nan_flag      = nan_reg;
    assign inexact_flag  = lost_reg;

    a_nan_canon: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg && nan_reg |-> bits_reg == fp16ta_pkg::CANON_NAN && !ovf_reg)
        else $error("NaN result not canonical");
    a_flags_excl: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg |-> $onehot0({ovf_reg, zero_reg, nan_reg}))
        else $error("conflicting result flags");
    a_ovf_inf: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg && ovf_reg |-> bits_reg[14:0] == fp16ta_pkg::INF_MAG)
        else $error("overflow without infinity");

endmodule

FILE: hw/rtl/fp16_truncating_adder_top.sv
// FP16 adder with truncation, no guard bits; rounds to zero if signs match.
// Drive operand_a and operand_b and pulse start; an operand pair is taken at
// every rising edge where start is high and busy is low. busy is always low,
// so a new pair can be given every cycle.
// Each transfer produces exactly one result: done is high for one cycle
// together with sum_bits and the four flags. The result passes through the
// three pipeline registers: operand ordering, alignment with add/subtract,
// and normalization.
// Throughput is one result per cycle.
// The receiver cannot stall; it must capture the result while done is high.
// Reset clears the stage valid bits, so no result appears until a new
// transfer; items in flight at reset are dropped.
// NaN or inf-inf gives 0x7FFF and nan_flag; other infs set overflow_flag.
module fp16_truncating_adder_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [15:0] operand_a,
    input  logic [15:0] operand_b,
    output logic        done,
    output logic [15:0] sum_bits,
    output logic        overflow_flag,
    output logic        zero_flag,
    output logic        nan_flag,
    output logic        inexact_flag
);

    logic               v1, v2;
    fp16ta_pkg::align_t d1;
    fp16ta_pkg::sum_t   d2;

    assign busy = 1'b0;

    fp16ta_align u_align (
        .clk(clk), .rst_n(rst_n), .in_valid(start && !busy),
        .operand_a(operand_a), .operand_b(operand_b),
        .out_valid(v1), .out_data(d1)
    );

    fp16ta_addsub u_addsub (
        .clk(clk), .rst_n(rst_n), .in_valid(v1), .in_data(d1),
        .out_valid(v2), .out_data(d2)
    );

    fp16ta_norm u_norm (
        .clk(clk), .rst_n(rst_n), .in_valid(v2), .in_data(d2),
        .out_valid(done), .sum_bits(sum_bits), .overflow_flag(overflow_flag),
        .zero_flag(zero_flag), .nan_flag(nan_flag), .inexact_flag(inexact_flag)
    );

endmodule
